// File: rtl/pd_tilt_stabilizer_openloop_drive_core_macros.svh
// assertion macros for the tilt stabilizer drive core
// used by the top level only; needs a clock and a synchronous reset
`ifndef PD_TILT_STABILIZER_OPENLOOP_DRIVE_CORE_MACROS_SVH
`define PD_TILT_STABILIZER_OPENLOOP_DRIVE_CORE_MACROS_SVH

// condition holds on every edge outside reset
`define PTSOD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds on the edge after the antecedent
`define PTSOD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequence holds on the same edge as the antecedent
`define PTSOD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/ptsod_pkg.sv
// shared types and constants for the tilt stabilizer drive core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptsod_pkg;

   // field widths
   localparam int unsigned PITCH_W = 17;
   localparam int unsigned GYRO_W  = 16;
   localparam int unsigned ERR_W   = 18;
   localparam int unsigned KP_W    = 14;
   localparam int unsigned KD_W    = 11;
   localparam int unsigned VOLT_W  = 11;
   localparam int unsigned PP_W    = 6;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned VOUT_W  = 12;
   localparam int unsigned RATE_W  = 14;
   localparam int unsigned SUM_W   = 33;
   localparam int unsigned CSR_W   = 14;

   // shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 20;
   localparam int unsigned MUL_B_W = 16;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   // stream payload widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RSP_USER_W = 2;

   // control constants
   localparam logic [RATE_W-2:0]  RATE_LIMIT  = 13'd7680;
   localparam logic [SUM_W-1:0]   SUM_LIMIT   = 33'd1966080;
   localparam logic [MUL_B_W-1:0] DEG2RAD_Q20 = 16'd18301;
   localparam logic [KP_W-1:0]    KP_MAX      = 14'd12800;
   localparam logic [KD_W-1:0]    KD_MAX      = 11'd1280;
   localparam logic [VOLT_W-1:0]  VOLT_MAX    = 11'd2000;
   localparam logic [16:0]        SPEED_MIN   = 17'd512;
   localparam int                 ANGLE_BAND  = 128;
   localparam int                 GYRO_BAND   = 32;

   // reset values of the control registers
   localparam logic [KP_W-1:0]   KP_RESET   = 14'd205;
   localparam logic [KD_W-1:0]   KD_RESET   = 11'd77;
   localparam logic [VOLT_W-1:0] VOLT_RESET = 11'd500;
   localparam logic [PP_W-1:0]   PP_RESET   = 6'd7;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_START  = 2'd1,
      CMD_STOP   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_RUN  = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_KP_GAIN   = 2'd0,
      CSR_KD_GAIN   = 2'd1,
      CSR_DRIVE_MV  = 2'd2,
      CSR_POLE_PAIR = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_P,
      ST_MUL_D,
      ST_SUM,
      ST_RATE,
      ST_MUL_PP,
      ST_MUL_K,
      ST_SPEED,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MSEL_ERR_KP,
      MSEL_GYRO_KD,
      MSEL_RATE_PP,
      MSEL_SCALE
   } mul_sel_type;

   // request to the shared multiplier
   typedef struct packed {
      logic                        en;
      logic signed [MUL_A_W-1:0]   a;
      logic signed [MUL_B_W-1:0]   b;
   } mul_req_type;

endpackage

`default_nettype wire

// File: rtl/ptsod_mul_unit.sv
// shared signed multiplier with registered product
// depends on ptsod_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptsod_mul_unit (
   input  wire logic                                      clock,
   input  wire ptsod_pkg::mul_req_type                    mul_req,
   output logic signed [ptsod_pkg::MUL_P_W-1:0]           mul_prod
);
   import ptsod_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   // one product per cycle, held when not enabled
   always_comb begin
      prod_in = prod_ff;
      if (mul_req.en) begin
         prod_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// File: rtl/pd_tilt_stabilizer_openloop_drive_core.sv
// an update transaction with the loop active steps through the states decode, mul_p, mul_d,
//   sum, rate, mul_pp, mul_k, speed and finish; start, stop, deadband and ignored commands
//   go from decode straight to finish, which waits until the response register is free;
//   four multiplier passes per update; req_tready is high only while the sequencer is idle
// reset: synchronous, active high; clears the loop state and reloads the control registers
// depends on ptsod_pkg, ptsod_mul_unit and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "pd_tilt_stabilizer_openloop_drive_core_macros.svh"

module pd_tilt_stabilizer_openloop_drive_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [16:0] pitch_angle, [32:17] gyro_rate, [33] imu_ready, [39:34] zero
   input  wire logic [ptsod_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command
   input  wire logic [ptsod_pkg::REQ_USER_W-1:0]     req_tuser,
   // response stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [15:0] speed_magnitude, [27:16] voltage_signed, [41:28] mech_rate,
   // [42] driver_enable, [43] loop_active, [47:44] zero
   output logic [ptsod_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [1:0] drive_action
   output logic [ptsod_pkg::RSP_USER_W-1:0]          rsp_tuser,
   // control register writes
   input  wire logic                                 csr_we,
   input  wire logic [1:0]                           csr_addr,
   input  wire logic [ptsod_pkg::CSR_W-1:0]          csr_wdata
);
   import ptsod_pkg::*;

   // sequencer
   state_type   state_ff, state_in;
   mul_sel_type mul_sel;
   logic        mul_en;
   mul_req_type mul_req;
   logic signed [MUL_P_W-1:0] mul_prod;
   logic        req_fire;

   // control registers
   logic [KP_W-1:0]   kp_ff, kp_in;
   logic [KD_W-1:0]   kd_ff, kd_in;
   logic [VOLT_W-1:0] volt_ff, volt_in;
   logic [PP_W-1:0]   pp_ff, pp_in;

   // loop state
   logic                      active_ff, active_in;
   logic                      enable_ff, enable_in;
   logic signed [PITCH_W-1:0] home_ff, home_in;
   logic signed [RATE_W-1:0]  last_rate_ff, last_rate_in;

   // captured transaction
   logic [1:0]                cmd_ff, cmd_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [GYRO_W-1:0]  gyro_ff, gyro_in;
   logic                      imu_rdy_ff, imu_rdy_in;

   // working values
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [31:0]        pterm_ff, pterm_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [RATE_W-2:0]         rate_abs_ff, rate_abs_in;

   // result fields
   logic [1:0]                act_ff, act_in;
   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic signed [VOUT_W-1:0]  vout_ff, vout_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]     rsp_user_ff, rsp_user_in;

   // combinational helpers
   logic signed [ERR_W-1:0]   err_now;
   logic                      in_band;
   logic [SUM_W-1:0]          sum_abs;
   logic [SUM_W-1:0]          sum_rnd;
   logic signed [RATE_W-1:0]  rate_now;
   logic [34:0]               speed_rnd;
   logic [16:0]               speed_full;
   logic                      out_free;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // shared multiplier
   ptsod_mul_unit u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (cmd_ff == CMD_UPDATE && active_ff && imu_rdy_ff && !in_band) begin
               state_in = ST_MUL_P;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL_P:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_RATE;
         ST_RATE:   state_in = ST_MUL_PP;
         ST_MUL_PP: state_in = ST_MUL_K;
         ST_MUL_K:  state_in = ST_SPEED;
         ST_SPEED:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      mul_sel    = MSEL_ERR_KP;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_MUL_P: begin
            mul_en  = 1'b1;
            mul_sel = MSEL_ERR_KP;
         end
         ST_MUL_D: begin
            mul_en  = 1'b1;
            mul_sel = MSEL_GYRO_KD;
         end
         ST_MUL_PP: begin
            mul_en  = 1'b1;
            mul_sel = MSEL_RATE_PP;
         end
         ST_MUL_K: begin
            mul_en  = 1'b1;
            mul_sel = MSEL_SCALE;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_req.en = mul_en;
      case (mul_sel)
         MSEL_ERR_KP: begin
            mul_req.a = MUL_A_W'(err_ff);
            mul_req.b = $signed({{(MUL_B_W-KP_W){1'b0}}, kp_ff});
         end
         MSEL_GYRO_KD: begin
            mul_req.a = MUL_A_W'(gyro_ff);
            mul_req.b = $signed({{(MUL_B_W-KD_W){1'b0}}, kd_ff});
         end
         MSEL_RATE_PP: begin
            mul_req.a = $signed({{(MUL_A_W-RATE_W+1){1'b0}}, rate_abs_ff});
            mul_req.b = $signed({{(MUL_B_W-PP_W){1'b0}}, pp_ff});
         end
         MSEL_SCALE: begin
            mul_req.a = mul_prod[MUL_A_W-1:0];
            mul_req.b = $signed(DEG2RAD_Q20);
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   // error and deadband
   assign err_now = ERR_W'(home_ff) - ERR_W'(pitch_ff);
   assign in_band = (err_now > -ERR_W'(ANGLE_BAND)) && (err_now < ERR_W'(ANGLE_BAND)) &&
                    (gyro_ff > -GYRO_W'(GYRO_BAND)) && (gyro_ff < GYRO_W'(GYRO_BAND));

   // clamp and round to nearest, ties away from zero
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign sum_rnd = sum_abs + SUM_W'(128);
   always_comb begin
      if (sum_ff > $signed(SUM_LIMIT)) begin
         rate_now = $signed({1'b0, RATE_LIMIT});
      end else if (sum_ff < -$signed(SUM_LIMIT)) begin
         rate_now = -$signed({1'b0, RATE_LIMIT});
      end else if (sum_ff[SUM_W-1]) begin
         rate_now = -$signed({1'b0, sum_rnd[RATE_W+6:8]});
      end else begin
         rate_now = $signed({1'b0, sum_rnd[RATE_W+6:8]});
      end
   end

   // electrical speed rounding
   assign speed_rnd  = mul_prod[34:0] + 35'd131072;
   assign speed_full = speed_rnd[34:18];

   // datapath and loop state
   always_comb begin
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      volt_in      = volt_ff;
      pp_in        = pp_ff;
      active_in    = active_ff;
      enable_in    = enable_ff;
      home_in      = home_ff;
      last_rate_in = last_rate_ff;
      cmd_in       = cmd_ff;
      pitch_in     = pitch_ff;
      gyro_in      = gyro_ff;
      imu_rdy_in   = imu_rdy_ff;
      err_in       = err_ff;
      pterm_in     = pterm_ff;
      sum_in       = sum_ff;
      rate_abs_in  = rate_abs_ff;
      act_in       = act_ff;
      speed_in     = speed_ff;
      vout_in      = vout_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // control register writes, out-of-range values dropped
      if (csr_we) begin
         case (csr_addr)
            CSR_KP_GAIN: begin
               if (csr_wdata[KP_W-1:0] <= KP_MAX) kp_in = csr_wdata[KP_W-1:0];
            end
            CSR_KD_GAIN: begin
               if (csr_wdata[KD_W-1:0] <= KD_MAX) kd_in = csr_wdata[KD_W-1:0];
            end
            CSR_DRIVE_MV: begin
               if (csr_wdata[VOLT_W-1:0] != '0 && csr_wdata[VOLT_W-1:0] <= VOLT_MAX) begin
                  volt_in = csr_wdata[VOLT_W-1:0];
               end
            end
            CSR_POLE_PAIR: pp_in = csr_wdata[PP_W-1:0];
            default: kp_in = kp_ff;
         endcase
      end

      // response handshake
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_tuser[1:0];
               pitch_in   = $signed(req_tdata[PITCH_W-1:0]);
               gyro_in    = $signed(req_tdata[PITCH_W+GYRO_W-1:PITCH_W]);
               imu_rdy_in = req_tdata[PITCH_W+GYRO_W];
            end
         end
         ST_DECODE: begin
            err_in   = err_now;
            act_in   = ACT_NONE;
            speed_in = '0;
            vout_in  = '0;
            case (cmd_ff)
               CMD_START: begin
                  if (!active_ff) begin
                     home_in      = pitch_ff;
                     last_rate_in = '0;
                     enable_in    = 1'b1;
                     active_in    = 1'b1;
                     act_in       = ACT_RUN;
                     vout_in      = $signed({1'b0, volt_ff});
                  end
               end
               CMD_STOP: begin
                  if (active_ff) begin
                     active_in    = 1'b0;
                     enable_in    = 1'b0;
                     last_rate_in = '0;
                     act_in       = ACT_STOP;
                  end
               end
               CMD_UPDATE: begin
                  if (active_ff) begin
                     act_in = ACT_RUN;
                     // deadband or stale imu data: zero-speed run
                     if (!imu_rdy_ff || in_band) last_rate_in = '0;
                  end
               end
               default: act_in = ACT_NONE;
            endcase
         end
         ST_MUL_D: pterm_in = mul_prod[31:0];
         ST_SUM: begin
            sum_in = SUM_W'(pterm_ff) - {mul_prod[28:0], 4'b0000};
         end
         ST_RATE: begin
            last_rate_in = rate_now;
            rate_abs_in  = rate_now[RATE_W-1] ? (RATE_W-1)'(-rate_now)
                                              : rate_now[RATE_W-2:0];
         end
         ST_SPEED: begin
            if (speed_full < SPEED_MIN) begin
               speed_in = '0;
               vout_in  = '0;
            end else begin
               speed_in = speed_full[SPEED_W-1:0];
               vout_in  = last_rate_ff[RATE_W-1] ? -$signed({1'b0, volt_ff})
                                                 : $signed({1'b0, volt_ff});
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = act_ff;
               rsp_data_in  = {4'b0000, active_ff, enable_ff, last_rate_ff, vout_ff, speed_ff};
            end
         end
         default: act_in = act_ff;
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kp_ff        <= KP_RESET;
         kd_ff        <= KD_RESET;
         volt_ff      <= VOLT_RESET;
         pp_ff        <= PP_RESET;
         active_ff    <= 1'b0;
         enable_ff    <= 1'b0;
         home_ff      <= '0;
         last_rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         volt_ff      <= volt_in;
         pp_ff        <= pp_in;
         active_ff    <= active_in;
         enable_ff    <= enable_in;
         home_ff      <= home_in;
         last_rate_ff <= last_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pitch_ff    <= pitch_in;
      gyro_ff     <= gyro_in;
      imu_rdy_ff  <= imu_rdy_in;
      err_ff      <= err_in;
      pterm_ff    <= pterm_in;
      sum_ff      <= sum_in;
      rate_abs_ff <= rate_abs_in;
      act_ff      <= act_in;
      speed_ff    <= speed_in;
      vout_ff     <= vout_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `PTSOD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready,
      "sequencer took a transaction without leaving idle")
   `PTSOD_ASSERT_ALWAYS(a_enable_tracks_active, clock, reset, enable_ff == active_ff,
      "driver enable differs from loop active")
   `PTSOD_ASSERT_ALWAYS(a_rate_in_limit, clock, reset,
      (last_rate_ff <= $signed({1'b0, RATE_LIMIT})) &&
      (last_rate_ff >= -$signed({1'b0, RATE_LIMIT})),
      "mechanical rate beyond clamp")
   `PTSOD_ASSERT_IMPLY(a_stop_clears, clock, reset,
      rsp_valid_ff && (rsp_user_ff == ACT_STOP),
      (rsp_data_ff[43:16] == '0),
      "stop response carries drive or state")

endmodule

`default_nettype wire
